>>> rtl/akl_pkg.sv
// Shared types, constants and keyword tables for the assembly keyword lexer.
// No dependencies; imported by every module of the block.
package akl_pkg;

  // Magnitude width of the number accumulator, sign included in the result.
  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int EXT_BITS   = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;
  localparam int PROD_BITS  = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam int KW_COUNT    = 6;
  localparam int WORD_LEN_W  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    TK_TEXT     = 3'd0,
    TK_START_FN = 3'd1,
    TK_MOVE     = 3'd2,
    TK_REGISTER = 3'd3,
    TK_SYSCALL  = 3'd4,
    TK_COMMA    = 3'd5,
    TK_NUMBER   = 3'd6
  } token_kind_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } num_phase_t;

  // One queue entry: the token of a finished word and/or a comma token
  typedef struct packed {
    logic                word_vld;
    token_kind_t         word_kind;
    logic [OUT_BITS-1:0] word_value;
    logic                word_reg_id;
    logic                comma;
  } tok_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Keyword spellings, first character in the most significant used byte
  function automatic logic [63:0] kw_str(input int k);
    logic [63:0] s;
    case (k)
      0:       s = 64'(".text");
      1:       s = 64'("_main():");
      2:       s = 64'("mov");
      3:       s = 64'("rax");
      4:       s = 64'("rdi");
      default: s = 64'("syscall");
    endcase
    return s;
  endfunction

  function automatic logic [WORD_LEN_W-1:0] kw_len(input int k);
    logic [WORD_LEN_W-1:0] n;
    case (k)
      0:       n = 4'd5;
      1:       n = 4'd8;
      2:       n = 4'd3;
      3:       n = 4'd3;
      4:       n = 4'd3;
      default: n = 4'd7;
    endcase
    return n;
  endfunction

  function automatic token_kind_t kw_kind(input int k);
    token_kind_t t;
    case (k)
      0:       t = TK_TEXT;
      1:       t = TK_START_FN;
      2:       t = TK_MOVE;
      3:       t = TK_REGISTER;
      4:       t = TK_REGISTER;
      default: t = TK_SYSCALL;
    endcase
    return t;
  endfunction

  function automatic logic kw_reg(input int k);
    return (k == 4);
  endfunction

  // Character of keyword k at position idx; only meaningful for idx < kw_len(k)
  function automatic logic [7:0] kw_char(input int k, input logic [WORD_LEN_W-1:0] idx);
    logic [63:0]           s;
    logic [WORD_LEN_W-1:0] sh;
    s  = kw_str(k);
    sh = kw_len(k) - 4'd1 - idx;
    return s[{sh[2:0], 3'b000} +: 8];
  endfunction

endpackage

>>> rtl/assembly_keyword_lexer.sv
// Top level of the assembly keyword lexer: front end, token queue, back end.
// Depends on akl_pkg, akl_front, akl_queue and akl_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_stall    | in_char_in
//  result   | out_valid / out_stall  | out_token_kind, out_number_value,
//           |                        | out_register_id, out_last
//
// One character is taken per clock while the queue has room; the front end
// classifies it in that cycle. Each result leaves the output register, one token
// per clock while out_stall is low; a word followed by a comma gives two tokens,
// so the result port sets the pace for that pair. A token passes the token queue
// and then the output register; a comma behind a word waits in the pending flag.
// in_stall rises only when the four-entry token queue is full.
// Synchronous reset clears word state, queue pointers and count, and output valid.
module assembly_keyword_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_token_kind,
  output logic signed [31:0] out_number_value,
  output logic               out_register_id,
  output logic               out_last
);
  import akl_pkg::*;

  logic        acc_en;
  logic        push;
  tok_entry_t  push_entry;
  logic        pop;
  tok_entry_t  pop_entry;
  q_status_t   status;
  token_kind_t kind;
  logic [OUT_BITS-1:0] value;

  // Accept a character whenever the queue has room
  assign in_stall = status.full;
  assign acc_en   = in_valid && !status.full;

  akl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_en     (acc_en),
    .char_in    (in_char_in),
    .push       (push),
    .push_entry (push_entry)
  );

  akl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (status)
  );

  akl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_entry  (pop_entry),
    .status     (status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (kind),
    .out_value  (value),
    .out_reg_id (out_register_id),
    .out_last   (out_last)
  );

  assign out_token_kind   = kind;
  assign out_number_value = signed'(value);

endmodule

>>> rtl/akl_front.sv
// Front end: accepts characters, tracks the current word and classifies it.
// Pushes one queue entry per delimiter that yields a token. Uses akl_pkg.
module akl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_en,
  input  logic [7:0]          char_in,
  output logic                push,
  output akl_pkg::tok_entry_t push_entry
);
  import akl_pkg::*;

  logic [WORD_LEN_W-1:0] wlen_r, wlen_nxt;
  logic [KW_COUNT-1:0]   flags_r, flags_nxt;
  num_phase_t            phase_r, phase_nxt;
  logic                  inval_r, inval_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;

  logic                  is_comma, is_delim, is_digit, is_lead_ws, is_sign;
  logic [PROD_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] acc_digit;
  logic                  num_ok, kw_hit;
  token_kind_t           kw_kind_sel;
  logic                  kw_reg_sel;
  logic [VALUE_BITS-1:0] num_val;
  logic [EXT_BITS-1:0]   num_ext;

  // Character classes
  always_comb begin
    is_comma   = (char_in == CH_COMMA);
    is_delim   = is_comma || (char_in == CH_SPACE) || (char_in == CH_NEWLINE);
    is_digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    is_lead_ws = (char_in == CH_TAB) || (char_in == CH_CR) ||
                 (char_in == CH_VT) || (char_in == CH_FF);
    is_sign    = (char_in == CH_PLUS) || (char_in == CH_MINUS);
  end

  // Multiply-by-ten accumulate, saturating at the magnitude cap
  always_comb begin
    prod = (PROD_BITS'(acc_r) << 3) + (PROD_BITS'(acc_r) << 1) +
           PROD_BITS'(char_in[3:0]);
    if ((acc_r >= MAG_CAP) || (prod > PROD_BITS'(MAG_CAP))) begin
      acc_digit = MAG_CAP;
    end else begin
      acc_digit = prod[VALUE_BITS-1:0];
    end
  end

  // Classify the finished word
  always_comb begin
    num_ok      = !inval_r && (phase_r == PH_DIGITS);
    kw_hit      = 1'b0;
    kw_kind_sel = TK_TEXT;
    kw_reg_sel  = 1'b0;
    // lowest keyword index wins
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (flags_r[k] && (wlen_r == kw_len(k))) begin
        kw_hit      = 1'b1;
        kw_kind_sel = kw_kind(k);
        kw_reg_sel  = kw_reg(k);
      end
    end
    if (neg_r) begin
      num_val = ~acc_r + VALUE_BITS'(1);
    end else if (acc_r >= MAG_CAP) begin
      num_val = MAG_CAP - VALUE_BITS'(1);
    end else begin
      num_val = acc_r;
    end
    num_ext = EXT_BITS'(signed'(num_val));

    push_entry.word_vld    = (wlen_r != '0) && (num_ok || kw_hit);
    push_entry.word_kind   = num_ok ? TK_NUMBER : kw_kind_sel;
    push_entry.word_value  = num_ok ? num_ext[OUT_BITS-1:0] : '0;
    push_entry.word_reg_id = num_ok ? 1'b0 : kw_reg_sel;
    push_entry.comma       = is_comma;
    push = acc_en && is_delim && (push_entry.word_vld || is_comma);
  end

  // Advance word state on each transfer
  always_comb begin
    wlen_nxt  = wlen_r;
    flags_nxt = flags_r;
    phase_nxt = phase_r;
    inval_nxt = inval_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (acc_en) begin
      if (is_delim) begin
        wlen_nxt  = '0;
        flags_nxt = '1;
        phase_nxt = PH_LEAD;
        inval_nxt = 1'b0;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else begin
        // drop keywords the word no longer prefixes
        for (int k = 0; k < KW_COUNT; k++) begin
          if ((wlen_r >= kw_len(k)) || (kw_char(k, wlen_r) != char_in)) begin
            flags_nxt[k] = 1'b0;
          end
        end
        if (wlen_r != '1) begin
          wlen_nxt = wlen_r + WORD_LEN_W'(1);
        end
        if (!inval_r) begin
          case (phase_r)
            PH_LEAD: begin
              if (is_lead_ws) begin
                phase_nxt = PH_LEAD;
              end else if (is_sign) begin
                neg_nxt   = (char_in == CH_MINUS);
                phase_nxt = PH_SIGN;
              end else if (is_digit) begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = acc_digit;
              end else begin
                inval_nxt = 1'b1;
              end
            end
            PH_SIGN, PH_DIGITS: begin
              if (is_digit) begin
                phase_nxt = PH_DIGITS;
                acc_nxt   = acc_digit;
              end else begin
                inval_nxt = 1'b1;
              end
            end
            default: inval_nxt = 1'b1;
          endcase
        end
      end
    end
  end

  // Hold word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= '0;
      flags_r <= '1;
      phase_r <= PH_LEAD;
      inval_r <= 1'b0;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      wlen_r  <= wlen_nxt;
      flags_r <= flags_nxt;
      phase_r <= phase_nxt;
      inval_r <= inval_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

>>> rtl/akl_queue.sv
// Short token queue between front and back ends, held in flip-flops.
// Uses akl_pkg for the entry type and depth.
module akl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  akl_pkg::tok_entry_t push_entry,
  input  logic                pop,
  output akl_pkg::tok_entry_t pop_entry,
  output akl_pkg::q_status_t  status
);
  import akl_pkg::*;

  tok_entry_t         ent_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  always_comb begin
    status.full  = (count_r == Q_CNT_W'(QUEUE_DEPTH));
    status.empty = (count_r == '0);
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    pop_entry    = ent_r[rd_ptr_r];
  end

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue empty but pointers differ");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + Q_CNT_W'(1)))
    else $error("queue push lost");
`endif

endmodule

>>> rtl/akl_back.sv
// Back end: unpacks queue entries into single tokens on the result channel.
// Holds the output register and a pending comma flag. Uses akl_pkg.
module akl_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  akl_pkg::tok_entry_t          pop_entry,
  input  akl_pkg::q_status_t           status,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output akl_pkg::token_kind_t         out_kind,
  output logic [akl_pkg::OUT_BITS-1:0] out_value,
  output logic                         out_reg_id,
  output logic                         out_last
);
  import akl_pkg::*;

  logic                valid_r, valid_nxt;
  logic                pend_r, pend_nxt;
  token_kind_t         kind_r, kind_nxt;
  logic [OUT_BITS-1:0] value_r, value_nxt;
  logic                reg_id_r, reg_id_nxt;
  logic                last_r, last_nxt;
  logic                load;

  // Refill the output register when empty or taken
  always_comb begin
    load       = !valid_r || !out_stall;
    pop        = 1'b0;
    valid_nxt  = valid_r;
    pend_nxt   = pend_r;
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    reg_id_nxt = reg_id_r;
    last_nxt   = last_r;
    if (load) begin
      if (pend_r) begin
        valid_nxt  = 1'b1;
        pend_nxt   = 1'b0;
        kind_nxt   = TK_COMMA;
        value_nxt  = '0;
        reg_id_nxt = 1'b0;
        last_nxt   = 1'b1;
      end else if (!status.empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        if (pop_entry.word_vld) begin
          kind_nxt   = pop_entry.word_kind;
          value_nxt  = pop_entry.word_value;
          reg_id_nxt = pop_entry.word_reg_id;
          last_nxt   = !pop_entry.comma;
          pend_nxt   = pop_entry.comma;
        end else begin
          kind_nxt   = TK_COMMA;
          value_nxt  = '0;
          reg_id_nxt = 1'b0;
          last_nxt   = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    reg_id_r <= reg_id_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign out_value  = value_r;
  assign out_reg_id = reg_id_r;
  assign out_last   = last_r;

`ifndef SYNTHESIS
  a_pend_behind_word: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (valid_r && !last_r && (kind_r != TK_COMMA)))
    else $error("pending comma without a word token in front");

  a_comma_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r == TK_COMMA)) |-> last_r)
    else $error("comma token not marked last");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (kind_r != TK_NUMBER)) |-> (value_r == '0))
    else $error("non-number token carries a value");
`endif

endmodule
